// File: sv/rwlq_pkg.sv
// Shared types and constants for the reader-writer lock queue unit.
package rwlq_pkg;

	localparam int unsigned TASK_W  = 8;
	localparam int unsigned ENTRY_W = TASK_W + 1;

	typedef enum logic [2:0] {
		KIND_READ_LOCK    = 3'd0,
		KIND_TRY_READ     = 3'd1,
		KIND_READ_UNLOCK  = 3'd2,
		KIND_WRITE_LOCK   = 3'd3,
		KIND_TRY_WRITE    = 3'd4,
		KIND_WRITE_UNLOCK = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_GRANTED  = 3'd0,
		ST_REFUSED  = 3'd1,
		ST_QUEUED   = 3'd2,
		ST_FULL     = 3'd3,
		ST_MISUSE   = 3'd4,
		ST_RELEASED = 3'd5
	} status_t;

	typedef struct packed {
		logic              writer;
		logic [TASK_W-1:0] task_id;
	} entry_t;

	typedef struct packed {
		status_t           status;
		logic              wake_valid;
		logic [TASK_W-1:0] wake_task;
	} result_t;

endpackage

// File: sv/reader_writer_lock_queue_unit.sv
// Top level of the reader-writer lock queue unit: request stage, queue memory, result register.
// Each request yields one result. The head entry of the wait queue is read from the
// synchronous queue memory when the request is taken and is held in its read register
// for the decision stage, where the lock state and queue pointers are updated and the
// result is loaded into the output register. A new request is taken once the previous
// one has left the decision stage, so only one request is in flight at a time; a
// stalled result holds the decision stage and, through it, the request side. Wake
// results report the task popped from the head of the queue; that task must send its
// request again.
module reader_writer_lock_queue_unit #(
	parameter int unsigned MAX_READERS = 255,
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned TASK_COUNT  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // task_id[7:0]
	input  logic [2:0]  s_axis_tuser,   // kind[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // status[2:0], wake_task[10:3], zero[15:11]
	output logic        m_axis_tuser    // wake_valid
);

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);

	logic                        valid_s1;
	rwlq_pkg::kind_t             kind_s1;
	logic [rwlq_pkg::TASK_W-1:0] id_s1;
	logic                        out_valid_q;
	rwlq_pkg::result_t           out_q;
	rwlq_pkg::result_t           result;
	rwlq_pkg::entry_t            head_entry;
	rwlq_pkg::entry_t            wr_data;
	logic [PW-1:0]               head_addr, wr_addr;
	logic                        wr_en, accept, fire;

	assign s_axis_tready = !valid_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign fire          = valid_s1 && (!out_valid_q || m_axis_tready);

	rwlq_mem #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(rwlq_pkg::ENTRY_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (head_addr),
		.rd_data (head_entry)
	);

	rwlq_core #(
		.MAX_READERS(MAX_READERS),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TASK_COUNT (TASK_COUNT)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.kind       (kind_s1),
		.task_id    (id_s1),
		.head_entry (head_entry),
		.head_addr  (head_addr),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= rwlq_pkg::kind_t'(s_axis_tuser);
			id_s1   <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_q.wake_task, out_q.status};
	assign m_axis_tuser  = out_q.wake_valid;

	a_wake_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.wake_valid |-> out_q.status == rwlq_pkg::ST_RELEASED)
		else $error("wake reported on a request that released nothing");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1 && !accept)
		else $error("second request taken while one is in the decision stage");

	a_no_wake_task: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.wake_valid |-> out_q.wake_task == '0)
		else $error("wake task set without a wake");

endmodule

// File: sv/rwlq_mem.sv
// Wait queue storage: one write port, one read port with registered data.
module rwlq_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 9
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/rwlq_core.sv
// Lock state registers, FIFO pointers and the per-request decision logic.
module rwlq_core #(
	parameter int unsigned MAX_READERS = 255,
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned TASK_COUNT  = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  rwlq_pkg::kind_t                kind,
	input  logic [rwlq_pkg::TASK_W-1:0]    task_id,
	input  rwlq_pkg::entry_t               head_entry,
	output logic [$clog2(QUEUE_DEPTH)-1:0] head_addr,
	output logic                           wr_en,
	output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
	output rwlq_pkg::entry_t               wr_data,
	output rwlq_pkg::result_t              result
);

	localparam int unsigned CW = $clog2(MAX_READERS + 1);
	localparam int unsigned PW = $clog2(QUEUE_DEPTH);
	localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_READERS);
	localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);
	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

	logic [CW-1:0] count_q, count_d;
	logic          writer_q, writer_d;
	logic [PW-1:0] head_q, tail_q;
	logic [FW-1:0] fill_q;
	logic          push, pop;
	logic          read_ok, write_ok, id_ok, full, empty;

	assign read_ok  = !writer_q && (count_q != CNT_MAX);
	assign write_ok = !writer_q && (count_q == '0);
	assign id_ok    = 32'(task_id) < 32'(TASK_COUNT);
	assign full     = fill_q == FILL_MAX;
	assign empty    = fill_q == '0;

	always_comb begin
		count_d  = count_q;
		writer_d = writer_q;
		push     = 1'b0;
		pop      = 1'b0;
		wr_data  = '{writer: 1'b0, task_id: task_id};
		result.status = rwlq_pkg::ST_REFUSED;
		unique case (kind)
			rwlq_pkg::KIND_READ_LOCK: begin
				if (!id_ok) begin
					result.status = rwlq_pkg::ST_REFUSED;
				end else if (read_ok) begin
					count_d       = count_q + CW'(1);
					result.status = rwlq_pkg::ST_GRANTED;
				end else if (full) begin
					result.status = rwlq_pkg::ST_FULL;
				end else begin
					push          = 1'b1;
					result.status = rwlq_pkg::ST_QUEUED;
				end
			end
			rwlq_pkg::KIND_TRY_READ: begin
				if (id_ok && read_ok) begin
					count_d       = count_q + CW'(1);
					result.status = rwlq_pkg::ST_GRANTED;
				end
			end
			rwlq_pkg::KIND_READ_UNLOCK: begin
				if (writer_q || count_q == '0) begin
					result.status = rwlq_pkg::ST_MISUSE;
				end else begin
					count_d       = count_q - CW'(1);
					result.status = rwlq_pkg::ST_RELEASED;
					// full count: only a waiting reader can take the freed slot
					if (count_q == CNT_MAX) begin
						pop = !empty && !head_entry.writer;
					end else if (count_q == CW'(1)) begin
						pop = !empty;
					end
				end
			end
			rwlq_pkg::KIND_WRITE_LOCK: begin
				wr_data.writer = 1'b1;
				if (!id_ok) begin
					result.status = rwlq_pkg::ST_REFUSED;
				end else if (write_ok) begin
					writer_d      = 1'b1;
					result.status = rwlq_pkg::ST_GRANTED;
				end else if (full) begin
					result.status = rwlq_pkg::ST_FULL;
				end else begin
					push          = 1'b1;
					result.status = rwlq_pkg::ST_QUEUED;
				end
			end
			rwlq_pkg::KIND_TRY_WRITE: begin
				if (id_ok && write_ok) begin
					writer_d      = 1'b1;
					result.status = rwlq_pkg::ST_GRANTED;
				end
			end
			rwlq_pkg::KIND_WRITE_UNLOCK: begin
				if (!writer_q) begin
					result.status = rwlq_pkg::ST_MISUSE;
				end else begin
					writer_d      = 1'b0;
					result.status = rwlq_pkg::ST_RELEASED;
					pop           = !empty;
				end
			end
			default: begin
				result.status = rwlq_pkg::ST_REFUSED;
			end
		endcase
		result.wake_valid = pop;
		result.wake_task  = pop ? head_entry.task_id : '0;
	end

	assign head_addr = head_q;
	assign wr_en     = fire && push;
	assign wr_addr   = tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			writer_q <= 1'b0;
			head_q   <= '0;
			tail_q   <= '0;
			fill_q   <= '0;
		end else if (fire) begin
			count_q  <= count_d;
			writer_q <= writer_d;
			if (push) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + PW'(1);
				fill_q <= fill_q + FW'(1);
			end
			if (pop) begin
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + PW'(1);
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("wait queue fill above depth");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0 || fill_q == FILL_MAX) |-> head_q == tail_q)
		else $error("head and tail disagree with fill");

	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		writer_q |-> count_q == '0)
		else $error("writer and readers hold the lock together");

	a_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		fire && push |=> fill_q == $past(fill_q) + FW'(1))
		else $error("queued request not counted");

endmodule

// File: tb/reader_writer_lock_queue_unit_test.sv
// Testbench for the reader-writer lock queue unit: directed table, then checked random traffic.
module reader_writer_lock_queue_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LOCK_MAX_READERS = 255;
	localparam int LOCK_QUEUE_DEPTH = 16;
	localparam int LOCK_TASK_COUNT  = 256;
	localparam int RESET_CYCLES     = 5;
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int SETTLE_CYCLES    = 20;

	localparam logic [2:0] KIND_RESERVED_A = 3'd6;
	localparam logic [2:0] KIND_RESERVED_B = 3'd7;

	typedef enum int {MIX_NOISE, MIX_CHURN, MIX_FILL, MIX_RAMP, MIX_DRAIN} traffic_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         task_id;
		logic               typed;
		rwlq_pkg::status_t  status;
		logic               wake_valid;
		logic [7:0]         wake_task;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;    // task_id[7:0]
	logic [2:0]  s_axis_tuser = '0;    // kind[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;         // status[2:0], wake_task[10:3], zero[15:11]
	logic        m_axis_tuser;         // wake_valid

	// lock model state
	logic [7:0]       lock_readers = '0;
	logic             lock_writer = 1'b0;
	rwlq_pkg::entry_t wait_fifo [LOCK_QUEUE_DEPTH];
	int               fifo_head = 0;
	int               fifo_tail = 0;
	int               fifo_fill = 0;

	rwlq_pkg::result_t expected_results [$];
	rwlq_pkg::entry_t  woken_tasks [$];
	directed_row_t     plan [22];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int results_checked = 0;
	int wakes_seen = 0;
	int drops_seen = 0;
	int requests_sent = 0;
	int peak_readers = 0;
	int stall_cycles = 0;

	reader_writer_lock_queue_unit #(
		.MAX_READERS(LOCK_MAX_READERS),
		.QUEUE_DEPTH(LOCK_QUEUE_DEPTH),
		.TASK_COUNT(LOCK_TASK_COUNT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic rwlq_pkg::status_t push_waiter(input logic [7:0] id,
			input logic writer);
		if (fifo_fill >= LOCK_QUEUE_DEPTH)
			return rwlq_pkg::ST_FULL;
		wait_fifo[fifo_tail] = {writer, id};
		fifo_tail = (fifo_tail == LOCK_QUEUE_DEPTH - 1) ? 0 : fifo_tail + 1;
		fifo_fill++;
		return rwlq_pkg::ST_QUEUED;
	endfunction

	function automatic logic pop_waiter(input logic readers_only, output rwlq_pkg::entry_t e);
		e = '0;
		if (fifo_fill == 0)
			return 1'b0;
		if (readers_only && wait_fifo[fifo_head].writer)
			return 1'b0;
		e = wait_fifo[fifo_head];
		fifo_head = (fifo_head == LOCK_QUEUE_DEPTH - 1) ? 0 : fifo_head + 1;
		fifo_fill--;
		return 1'b1;
	endfunction

	function automatic rwlq_pkg::result_t arbitrate_request(input logic [2:0] kind,
			input logic [7:0] id, output rwlq_pkg::entry_t woken);
		rwlq_pkg::result_t res;
		logic              read_ok;
		logic              write_ok;
		logic              id_ok;
		logic [7:0]        prior;
		res.status = rwlq_pkg::ST_REFUSED;
		res.wake_valid = 1'b0;
		res.wake_task = '0;
		woken = '0;
		read_ok = !lock_writer && (int'(lock_readers) < LOCK_MAX_READERS);
		write_ok = !lock_writer && (lock_readers == 0);
		id_ok = int'(id) < LOCK_TASK_COUNT;
		case (kind)
			rwlq_pkg::KIND_READ_LOCK: begin
				if (!id_ok)
					res.status = rwlq_pkg::ST_REFUSED;
				else if (read_ok) begin
					lock_readers++;
					res.status = rwlq_pkg::ST_GRANTED;
				end else
					res.status = push_waiter(id, 1'b0);
			end
			rwlq_pkg::KIND_TRY_READ: begin
				if (id_ok && read_ok) begin
					lock_readers++;
					res.status = rwlq_pkg::ST_GRANTED;
				end
			end
			rwlq_pkg::KIND_READ_UNLOCK: begin
				if (lock_writer || lock_readers == 0)
					res.status = rwlq_pkg::ST_MISUSE;
				else begin
					prior = lock_readers;
					lock_readers--;
					res.status = rwlq_pkg::ST_RELEASED;
					if (int'(prior) >= LOCK_MAX_READERS)
						res.wake_valid = pop_waiter(1'b1, woken);
					else if (prior == 1)
						res.wake_valid = pop_waiter(1'b0, woken);
				end
			end
			rwlq_pkg::KIND_WRITE_LOCK: begin
				if (!id_ok)
					res.status = rwlq_pkg::ST_REFUSED;
				else if (write_ok) begin
					lock_writer = 1'b1;
					res.status = rwlq_pkg::ST_GRANTED;
				end else
					res.status = push_waiter(id, 1'b1);
			end
			rwlq_pkg::KIND_TRY_WRITE: begin
				if (id_ok && write_ok) begin
					lock_writer = 1'b1;
					res.status = rwlq_pkg::ST_GRANTED;
				end
			end
			rwlq_pkg::KIND_WRITE_UNLOCK: begin
				if (!lock_writer)
					res.status = rwlq_pkg::ST_MISUSE;
				else begin
					lock_writer = 1'b0;
					res.status = rwlq_pkg::ST_RELEASED;
					res.wake_valid = pop_waiter(1'b0, woken);
				end
			end
			default: res.status = rwlq_pkg::ST_REFUSED;
		endcase
		if (res.wake_valid)
			res.wake_task = woken.task_id;
		return res;
	endfunction

	function automatic logic [2:0] held_unlock();
		if (lock_writer)
			return rwlq_pkg::KIND_WRITE_UNLOCK;
		if (lock_readers != 0)
			return rwlq_pkg::KIND_READ_UNLOCK;
		return rwlq_pkg::KIND_WRITE_LOCK;
	endfunction

	function automatic void pick_request(input traffic_t mix, output logic [2:0] kind,
			output logic [7:0] id);
		int               roll;
		rwlq_pkg::entry_t w;
		id = 8'($urandom_range(0, 255));
		roll = $urandom_range(0, 99);
		kind = rwlq_pkg::KIND_READ_LOCK;
		if (((mix == MIX_CHURN && roll < 60) || mix == MIX_DRAIN)
				&& woken_tasks.size() != 0) begin
			w = woken_tasks.pop_front();
			kind = w.writer ? rwlq_pkg::KIND_WRITE_LOCK : rwlq_pkg::KIND_READ_LOCK;
			id = w.task_id;
			return;
		end
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_NOISE: kind = 3'($urandom_range(0, 7));
			MIX_FILL: begin
				if (!lock_writer && lock_readers == 0)
					kind = rwlq_pkg::KIND_WRITE_LOCK;
				else if (roll < 45)
					kind = rwlq_pkg::KIND_READ_LOCK;
				else if (roll < 90)
					kind = rwlq_pkg::KIND_WRITE_LOCK;
				else if (roll < 95)
					kind = rwlq_pkg::KIND_TRY_READ;
				else
					kind = rwlq_pkg::KIND_TRY_WRITE;
			end
			MIX_RAMP: begin
				if (roll < 70 || lock_readers == 0)
					kind = rwlq_pkg::KIND_READ_LOCK;
				else if (roll < 90)
					kind = rwlq_pkg::KIND_TRY_READ;
				else
					kind = rwlq_pkg::KIND_WRITE_LOCK;
			end
			MIX_CHURN: begin
				if (roll < 15)
					kind = rwlq_pkg::KIND_READ_LOCK;
				else if (roll < 25)
					kind = rwlq_pkg::KIND_TRY_READ;
				else if (roll < 37)
					kind = rwlq_pkg::KIND_WRITE_LOCK;
				else if (roll < 45)
					kind = rwlq_pkg::KIND_TRY_WRITE;
				else if (roll < 80)
					kind = held_unlock();
				else if (roll < 92)
					kind = roll[0] ? rwlq_pkg::KIND_READ_UNLOCK : rwlq_pkg::KIND_WRITE_UNLOCK;
				else
					kind = 3'($urandom_range(0, 7));
			end
			MIX_DRAIN: begin
				if (lock_writer || lock_readers != 0)
					kind = held_unlock();
				else
					kind = 3'($urandom_range(0, 7));
			end
			default: kind = rwlq_pkg::KIND_READ_LOCK;
		endcase
	endfunction

	task automatic send_request(input logic [2:0] kind, input logic [7:0] id, input logic typed,
			input rwlq_pkg::result_t typed_res);
		rwlq_pkg::result_t res;
		rwlq_pkg::entry_t  woken;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= id;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		res = arbitrate_request(kind, id, woken);
		expected_results.push_back(typed ? typed_res : res);
		if (res.wake_valid)
			woken_tasks.push_back(woken);
		if (int'(lock_readers) > peak_readers)
			peak_readers = lock_readers;
		requests_sent++;
	endtask

	task automatic run_traffic(input traffic_t mix, input int max_items);
		logic [2:0] kind;
		logic [7:0] id;
		for (int n = 0; n < max_items; n++) begin
			if (mix == MIX_RAMP && int'(lock_readers) == LOCK_MAX_READERS)
				break;
			if (mix == MIX_DRAIN && !lock_writer && lock_readers == 0 && fifo_fill == 0
					&& woken_tasks.size() == 0)
				break;
			pick_request(mix, kind, id);
			send_request(kind, id, 1'b0, '0);
		end
	endtask

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("MISMATCH result %0d %s: got %0d expected %0d", results_checked, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		rwlq_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0)
				report_mismatch("unexpected result, status", m_axis_tdata[2:0], -1);
			else begin
				want = expected_results.pop_front();
				if (m_axis_tdata[2:0] !== want.status)
					report_mismatch("status", m_axis_tdata[2:0], want.status);
				if (m_axis_tuser !== want.wake_valid)
					report_mismatch("wake_valid", m_axis_tuser, want.wake_valid);
				if (m_axis_tdata[10:3] !== want.wake_task)
					report_mismatch("wake_task", m_axis_tdata[10:3], want.wake_task);
				if (m_axis_tdata[15:11] !== 5'd0)
					report_mismatch("padding", m_axis_tdata[15:11], 0);
				if (want.wake_valid)
					wakes_seen++;
				if (want.status == rwlq_pkg::ST_FULL)
					drops_seen++;
			end
			results_checked++;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		plan = '{
			'{rwlq_pkg::KIND_READ_UNLOCK,  8'h00, 1'b1, rwlq_pkg::ST_MISUSE,  1'b0, 8'h00},
			'{rwlq_pkg::KIND_WRITE_UNLOCK, 8'h00, 1'b1, rwlq_pkg::ST_MISUSE,  1'b0, 8'h00},
			'{KIND_RESERVED_A,             8'h55, 1'b1, rwlq_pkg::ST_REFUSED, 1'b0, 8'h00},
			'{KIND_RESERVED_B,             8'hAA, 1'b1, rwlq_pkg::ST_REFUSED, 1'b0, 8'h00},
			'{rwlq_pkg::KIND_TRY_READ,     8'hFF, 1'b1, rwlq_pkg::ST_GRANTED, 1'b0, 8'h00},
			'{rwlq_pkg::KIND_TRY_WRITE,    8'h00, 1'b1, rwlq_pkg::ST_REFUSED, 1'b0, 8'h00},
			'{rwlq_pkg::KIND_WRITE_LOCK,   8'h12, 1'b1, rwlq_pkg::ST_QUEUED,  1'b0, 8'h00},
			'{rwlq_pkg::KIND_READ_LOCK,    8'h34, 1'b0, rwlq_pkg::ST_GRANTED, 1'b0, 8'h00},
			'{rwlq_pkg::KIND_READ_UNLOCK,  8'h34, 1'b0, rwlq_pkg::ST_GRANTED, 1'b0, 8'h00},
			'{rwlq_pkg::KIND_READ_UNLOCK,  8'hFF, 1'b0, rwlq_pkg::ST_GRANTED, 1'b0, 8'h00},
			'{rwlq_pkg::KIND_WRITE_LOCK,   8'h12, 1'b0, rwlq_pkg::ST_GRANTED, 1'b0, 8'h00},
			'{rwlq_pkg::KIND_WRITE_LOCK,   8'hFF, 1'b0, rwlq_pkg::ST_GRANTED, 1'b0, 8'h00},
			'{rwlq_pkg::KIND_READ_LOCK,    8'h00, 1'b0, rwlq_pkg::ST_GRANTED, 1'b0, 8'h00},
			'{rwlq_pkg::KIND_TRY_READ,     8'h01, 1'b1, rwlq_pkg::ST_REFUSED, 1'b0, 8'h00},
			'{rwlq_pkg::KIND_READ_UNLOCK,  8'h01, 1'b1, rwlq_pkg::ST_MISUSE,  1'b0, 8'h00},
			'{rwlq_pkg::KIND_TRY_WRITE,    8'hFE, 1'b1, rwlq_pkg::ST_REFUSED, 1'b0, 8'h00},
			'{rwlq_pkg::KIND_WRITE_UNLOCK, 8'h12, 1'b0, rwlq_pkg::ST_GRANTED, 1'b0, 8'h00},
			'{rwlq_pkg::KIND_WRITE_LOCK,   8'hFF, 1'b0, rwlq_pkg::ST_GRANTED, 1'b0, 8'h00},
			'{rwlq_pkg::KIND_WRITE_UNLOCK, 8'hFF, 1'b0, rwlq_pkg::ST_GRANTED, 1'b0, 8'h00},
			'{rwlq_pkg::KIND_READ_LOCK,    8'h00, 1'b0, rwlq_pkg::ST_GRANTED, 1'b0, 8'h00},
			'{rwlq_pkg::KIND_READ_UNLOCK,  8'h00, 1'b0, rwlq_pkg::ST_GRANTED, 1'b0, 8'h00},
			'{rwlq_pkg::KIND_WRITE_UNLOCK, 8'h80, 1'b1, rwlq_pkg::ST_MISUSE,  1'b0, 8'h00}
		};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(plan); i++)
			send_request(plan[i].kind, plan[i].task_id, plan[i].typed,
				{plan[i].status, plan[i].wake_valid, plan[i].wake_task});
		woken_tasks.delete();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			run_traffic(MIX_FILL, 30);
			run_traffic(MIX_CHURN, 90);
			run_traffic(MIX_NOISE, 25);
			run_traffic(MIX_DRAIN, 700);
			// saturate the reader count so the full-count wakeup rule gets exercised
			if (phase == 2) begin
				run_traffic(MIX_RAMP, 400);
				run_traffic(MIX_FILL, 12);
				run_traffic(MIX_DRAIN, 700);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests, checked %0d results, %0d mismatches",
			requests_sent, results_checked, mismatches);
		$display("Saw %0d wakeups, %0d queue-full drops, peak reader count %0d",
			wakes_seen, drops_seen, peak_readers);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
